// ===== hw/rtl/sfi_pkg.sv =====
// ----------------------------------------------------------------------------
// sfi_pkg
// Shared types and constants of the sonar fusion IIR filter.
// ----------------------------------------------------------------------------
package sfi_pkg;

	localparam int SUM_W = 20;  // ten 16-bit samples
	localparam int HL_W  = 20;  // height limit width

	localparam logic [6:0] ID_X  = 7'h70;
	localparam logic [6:0] ID_Y  = 7'h73;
	localparam logic [6:0] ID_H0 = 7'h7C;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_X,
		CLS_Y,
		CLS_H
	} cls_t;

	// one classified request passed from front to back
	typedef struct packed {
		cls_t             cls;
		logic [1:0]       hidx;
		logic [SUM_W-1:0] sum;
		logic             eom;
	} rec_t;

endpackage

// ===== hw/rtl/sonar_fusion_iir_filter_top.sv =====
// ----------------------------------------------------------------------------
// sonar_fusion_iir_filter_top
// Sonar fusion with three fourth-order direct form I IIR filters.
// ----------------------------------------------------------------------------
// Flow: a record without end mark passes the back states idle and accumulate;
//   an end record also passes setup, the height mean divider (skipped when no
//   height is valid), three filter passes on the shared multiplier and output.
// The back takes no new record until it has finished the previous one, end
//   records included; the queue in front holds the records in between.
// Reset: arst_n clears all filter histories, accumulators and queue, and
//   loads height_limit with 6000.
// ----------------------------------------------------------------------------
module sonar_fusion_iir_filter_top #(
	parameter int SAMPLES_PER_RECORD = 10,
	parameter int COEF_FRAC_BITS     = 24,
	parameter int QUEUE_DEPTH        = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [19:0]        cfg_data,
	// sonar request channel
	input  logic               sonar_valid,
	output logic               sonar_stall,
	input  logic [6:0]         sonar_id,
	input  logic [15:0]        dist_0,
	input  logic [15:0]        dist_1,
	input  logic [15:0]        dist_2,
	input  logic [15:0]        dist_3,
	input  logic [15:0]        dist_4,
	input  logic [15:0]        dist_5,
	input  logic [15:0]        dist_6,
	input  logic [15:0]        dist_7,
	input  logic [15:0]        dist_8,
	input  logic [15:0]        dist_9,
	input  logic               end_of_message,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] filtered_x,
	output logic signed [31:0] filtered_y,
	output logic signed [31:0] filtered_z,
	output logic [2:0]         valid_heights
);

	logic [sfi_pkg::HL_W-1:0] height_limit_q;
	logic [9:0][15:0]         dist_vec;
	logic                     push, pop, q_full, q_avail;
	sfi_pkg::rec_t            front_rec, back_rec;

	// the single register is always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_limit_q <= 20'd6000;
		end else if (cfg_valid && cfg_ready) begin
			height_limit_q <= cfg_data;
		end
	end

	assign dist_vec = {dist_9, dist_8, dist_7, dist_6, dist_5,
	                   dist_4, dist_3, dist_2, dist_1, dist_0};

	// front: sum the samples and classify the id
	sfi_front #(
		.SAMPLES_PER_RECORD(SAMPLES_PER_RECORD)
	) u_front (
		.sonar_valid   (sonar_valid),
		.sonar_stall   (sonar_stall),
		.sonar_id      (sonar_id),
		.dist_vec      (dist_vec),
		.end_of_message(end_of_message),
		.q_full        (q_full),
		.push          (push),
		.rec           (front_rec)
	);

	// decouple so the front keeps taking requests while the filters run, until the queue is full
	sfi_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (front_rec),
		.pop   (pop),
		.rdata (back_rec),
		.full  (q_full),
		.avail (q_avail)
	);

	// back: accumulate, divide for the height mean, filter, hold the result
	sfi_back #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.height_limit (height_limit_q),
		.rec          (back_rec),
		.rec_avail    (q_avail),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.filtered_x   (filtered_x),
		.filtered_y   (filtered_y),
		.filtered_z   (filtered_z),
		.valid_heights(valid_heights)
	);

	// never write into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("push into full queue");

	// never pop an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_avail) else $error("pop from empty queue");

	// a new result only appears after the previous one was taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("result dropped while stalled");

endmodule

// ===== hw/rtl/sfi_front.sv =====
// ----------------------------------------------------------------------------
// sfi_front
// Accepts sonar requests, sums the samples and classifies the sonar id.
// ----------------------------------------------------------------------------
module sfi_front #(
	parameter int SAMPLES_PER_RECORD = 10
) (
	input  logic              sonar_valid,
	output logic              sonar_stall,
	input  logic [6:0]        sonar_id,
	input  logic [9:0][15:0]  dist_vec,
	input  logic              end_of_message,
	input  logic              q_full,
	output logic              push,
	output sfi_pkg::rec_t     rec
);

	logic [sfi_pkg::SUM_W-1:0] sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < 10; i++) begin
			if (i < SAMPLES_PER_RECORD) begin
				sum = sum + sfi_pkg::SUM_W'(dist_vec[i]);
			end
		end
	end

	always_comb begin
		rec.sum  = sum;
		rec.eom  = end_of_message;
		rec.hidx = sonar_id[1:0];
		if (sonar_id == sfi_pkg::ID_X) begin
			rec.cls = sfi_pkg::CLS_X;
		end else if (sonar_id == sfi_pkg::ID_Y) begin
			rec.cls = sfi_pkg::CLS_Y;
		end else if (sonar_id >= sfi_pkg::ID_H0) begin
			rec.cls = sfi_pkg::CLS_H;
		end else begin
			rec.cls = sfi_pkg::CLS_NONE;
		end
	end

	// hold off while the queue is full
	assign sonar_stall = q_full;
	assign push        = sonar_valid && !q_full;

endmodule

// ===== hw/rtl/sfi_queue.sv =====
// ----------------------------------------------------------------------------
// sfi_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module sfi_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfi_pkg::rec_t wdata,
	input  logic          pop,
	output sfi_pkg::rec_t rdata,
	output logic          full,
	output logic          avail
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	sfi_pkg::rec_t  mem_q [DEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [CNTW-1:0] cnt_q;

	assign full  = (cnt_q == CNTW'(DEPTH));
	assign avail = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/sfi_back.sv =====
// ----------------------------------------------------------------------------
// sfi_back
// Accumulates records, forms the raw x/y/z, runs the three filters on one
// shared multiplier and holds the result register.
// ----------------------------------------------------------------------------
module sfi_back #(
	parameter int COEF_FRAC_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sfi_pkg::HL_W-1:0]   height_limit,
	input  sfi_pkg::rec_t              rec,
	input  logic                       rec_avail,
	output logic                       pop,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [31:0]         filtered_x,
	output logic signed [31:0]         filtered_y,
	output logic signed [31:0]         filtered_z,
	output logic [2:0]                 valid_heights
);

	localparam int F  = COEF_FRAC_BITS;
	localparam int CW = F + 3;
	localparam int PRW = CW + 25;
	localparam int AW = CW + 48 + 4;
	localparam int DVW = 30;

	localparam longint M_A1 = ((longint'(3159) << F) + 500) / 1000;
	localparam longint M_A2 = ((longint'(3815) << F) + 500) / 1000;
	localparam longint M_A3 = ((longint'(2076) << F) + 500) / 1000;
	localparam longint M_A4 = ((longint'(4291) << F) + 5000) / 10000;
	localparam longint M_B0 = ((longint'(1223) << F) + 50000) / 100000;
	localparam longint M_B1 = ((longint'(2416) << F) + 50000) / 100000;
	localparam longint M_B2 = ((longint'(3202) << F) + 50000) / 100000;

	localparam logic signed [CW-1:0] C_A1 = CW'(M_A1);
	localparam logic signed [CW-1:0] C_A2 = CW'(-M_A2);
	localparam logic signed [CW-1:0] C_A3 = CW'(M_A3);
	localparam logic signed [CW-1:0] C_A4 = CW'(-M_A4);
	localparam logic signed [CW-1:0] C_B0 = CW'(M_B0);
	localparam logic signed [CW-1:0] C_B1 = CW'(-M_B1);
	localparam logic signed [CW-1:0] C_B2 = CW'(M_B2);

	localparam logic signed [AW-1:0] RND_W  = AW'(1) <<< (F - 1);
	localparam logic signed [AW-1:0] S48MAX = {{(AW-47){1'b0}}, {47{1'b1}}};
	localparam logic signed [AW-1:0] S48MIN = {{(AW-47){1'b1}}, {47{1'b0}}};

	localparam logic [4:0] LAST_STEP = 5'd18;
	localparam logic [4:0] DIV_STEPS = 5'(DVW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_SETUP,
		ST_DIV,
		ST_FILT,
		ST_ROUND,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -48'sh0000_8000_0000) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat_x256(input logic signed [31:0] v);
		if (v > 32'sh007F_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -32'sh0080_0000) begin
			return 32'sh8000_0000;
		end
		return {v[23:0], 8'h00};
	endfunction

	state_t                  state_q;
	sfi_pkg::rec_t           rec_q;
	logic signed [31:0]      x_acc_q, y_acc_q;
	logic [sfi_pkg::HL_W-1:0] h_acc_q [4];
	logic [2:0]              vc_q, vc_out_q, vh_out_q;
	logic signed [31:0]      raw_hist_q [12];
	logic signed [47:0]      filt_hist_q [12];
	logic signed [31:0]      raw_new_q [3];
	logic signed [31:0]      fout_q [3];
	logic [DVW-1:0]          dq_q;
	logic [2:0]              rem_q;
	logic [4:0]              div_cnt_q;
	logic [1:0]              ch_q;
	logic [4:0]              step_q;
	logic signed [PRW-1:0]   prod_s1;
	logic                    prod_vld_s1, prod_hi_s1;
	logic signed [AW-1:0]    acc_q;

	// accumulate arithmetic
	logic signed [32:0]      xt, yt;
	logic [sfi_pkg::HL_W:0]  ht;
	logic [21:0]             hsum;
	logic [DVW-1:0]          dividend;
	logic [3:0]              r2;

	always_comb begin
		xt   = {x_acc_q[31], x_acc_q} - $signed({13'b0, rec_q.sum});
		yt   = {y_acc_q[31], y_acc_q} + $signed({13'b0, rec_q.sum});
		ht   = {1'b0, h_acc_q[rec_q.hidx]} + (sfi_pkg::HL_W + 1)'(rec_q.sum);
		hsum = 22'(h_acc_q[0]) + 22'(h_acc_q[1]) + 22'(h_acc_q[2]) + 22'(h_acc_q[3]);
		dividend = {hsum, 8'h00} + DVW'(vc_q >> 1);
		r2   = {rem_q, dq_q[DVW-1]};
	end

	// filter operand selection
	logic [3:0]              term;
	logic [3:0]              hidx;
	logic signed [47:0]      opv;
	logic signed [CW-1:0]    coef;
	logic signed [24:0]      part;

	always_comb begin
		term = step_q[4:1];
		hidx = {ch_q, 2'b00};
		opv  = '0;
		coef = C_B0;
		case (term)
			4'd0: begin opv = filt_hist_q[hidx];         coef = C_A1; end
			4'd1: begin opv = filt_hist_q[hidx + 4'd1];  coef = C_A2; end
			4'd2: begin opv = filt_hist_q[hidx + 4'd2];  coef = C_A3; end
			4'd3: begin opv = filt_hist_q[hidx + 4'd3];  coef = C_A4; end
			4'd4: begin opv = 48'(raw_new_q[ch_q]);      coef = C_B0; end
			4'd5: begin opv = 48'(raw_hist_q[hidx]);     coef = C_B1; end
			4'd6: begin opv = 48'(raw_hist_q[hidx + 4'd1]); coef = C_B2; end
			4'd7: begin opv = 48'(raw_hist_q[hidx + 4'd2]); coef = C_B1; end
			4'd8: begin opv = 48'(raw_hist_q[hidx + 4'd3]); coef = C_B0; end
			default: begin opv = '0; coef = C_B0; end
		endcase
		part = step_q[0] ? $signed({opv[47], opv[47:24]}) : $signed({1'b0, opv[23:0]});
	end

	// rounding of the finished sum
	logic signed [AW-1:0]    rnd;
	logic signed [47:0]      fnew;

	always_comb begin
		rnd = (acc_q + RND_W) >>> F;
		if (rnd > S48MAX) begin
			fnew = 48'sh7FFF_FFFF_FFFF;
		end else if (rnd < S48MIN) begin
			fnew = -48'sh7FFF_FFFF_FFFF - 48'sd1;
		end else begin
			fnew = rnd[47:0];
		end
	end

	assign pop           = (state_q == ST_IDLE) && rec_avail;
	assign filtered_x    = fout_q[0];
	assign filtered_y    = fout_q[1];
	assign filtered_z    = fout_q[2];
	assign valid_heights = vh_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rec_q        <= '0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
			vc_q         <= '0;
			vc_out_q     <= '0;
			vh_out_q     <= '0;
			dq_q         <= '0;
			rem_q        <= '0;
			div_cnt_q    <= '0;
			ch_q         <= '0;
			step_q       <= '0;
			prod_s1      <= '0;
			prod_vld_s1  <= 1'b0;
			prod_hi_s1   <= 1'b0;
			acc_q        <= '0;
			result_valid <= 1'b0;
			for (int i = 0; i < 4; i++) h_acc_q[i] <= '0;
			for (int i = 0; i < 12; i++) begin
				raw_hist_q[i]  <= '0;
				filt_hist_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				raw_new_q[i] <= '0;
				fout_q[i]    <= '0;
			end
		end else begin
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end

			// multiplier stage, registered before the accumulate
			prod_s1     <= coef * part;
			prod_hi_s1  <= step_q[0];
			prod_vld_s1 <= (state_q == ST_FILT) && (step_q != LAST_STEP);
			if (prod_vld_s1) begin
				acc_q <= prod_hi_s1 ? acc_q + (AW'(prod_s1) <<< 24) : acc_q + AW'(prod_s1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (rec_avail) begin
						rec_q   <= rec;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					case (rec_q.cls)
						sfi_pkg::CLS_X: begin
							x_acc_q <= (xt[32] != xt[31]) ? 32'sh8000_0000 : xt[31:0];
						end
						sfi_pkg::CLS_Y: begin
							y_acc_q <= (yt[32] != yt[31]) ? 32'sh7FFF_FFFF : yt[31:0];
						end
						sfi_pkg::CLS_H: begin
							if (ht > (sfi_pkg::HL_W + 1)'(height_limit)) begin
								h_acc_q[rec_q.hidx] <= '0;
							end else begin
								h_acc_q[rec_q.hidx] <= ht[sfi_pkg::HL_W-1:0];
								if (vc_q != 3'd7) vc_q <= vc_q + 3'd1;
							end
						end
						default: ;
					endcase
					state_q <= rec_q.eom ? ST_SETUP : ST_IDLE;
				end
				ST_SETUP: begin
					raw_new_q[0] <= sat_x256(x_acc_q);
					raw_new_q[1] <= sat_x256(y_acc_q);
					vc_out_q     <= vc_q;
					dq_q         <= dividend;
					rem_q        <= '0;
					div_cnt_q    <= '0;
					ch_q         <= '0;
					step_q       <= '0;
					acc_q        <= '0;
					// clear the message accumulators
					x_acc_q      <= '0;
					y_acc_q      <= '0;
					vc_q         <= '0;
					for (int i = 0; i < 4; i++) h_acc_q[i] <= '0;
					if (vc_q == '0) begin
						raw_new_q[2] <= raw_hist_q[8];
						state_q      <= ST_FILT;
					end else begin
						state_q      <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					if (r2 >= {1'b0, vc_out_q}) begin
						rem_q <= 3'(r2 - {1'b0, vc_out_q});
						dq_q  <= {dq_q[DVW-2:0], 1'b1};
					end else begin
						rem_q <= r2[2:0];
						dq_q  <= {dq_q[DVW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == DIV_STEPS - 5'd1) begin
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					if (div_cnt_q == DIV_STEPS) begin
						raw_new_q[2] <= 32'(dq_q);
						div_cnt_q    <= '0;
					end
					if (step_q == LAST_STEP) begin
						state_q <= ST_ROUND;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_ROUND: begin
					for (int c = 0; c < 3; c++) begin
						if (ch_q == 2'(c)) begin
							raw_hist_q[c*4+3]  <= raw_hist_q[c*4+2];
							raw_hist_q[c*4+2]  <= raw_hist_q[c*4+1];
							raw_hist_q[c*4+1]  <= raw_hist_q[c*4];
							raw_hist_q[c*4]    <= raw_new_q[c];
							filt_hist_q[c*4+3] <= filt_hist_q[c*4+2];
							filt_hist_q[c*4+2] <= filt_hist_q[c*4+1];
							filt_hist_q[c*4+1] <= filt_hist_q[c*4];
							filt_hist_q[c*4]   <= fnew;
						end
					end
					step_q <= '0;
					acc_q  <= '0;
					if (ch_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_FILT;
					end
				end
				ST_OUT: begin
					// load the result register only once the previous result is gone
					if (!result_valid) begin
						for (int c = 0; c < 3; c++) begin
							fout_q[c] <= sat32(filt_hist_q[c*4]);
						end
						vh_out_q     <= vc_out_q;
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
